// ===== hw/rtl/qrs_pkg.sv =====
// qrs_pkg: widths, stage counts and shared types of the quadratic root solver.
// No dependencies; every other file in hw/rtl uses it by scoped name.
package qrs_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_WIDTH  = 33;

  localparam int DISC_WIDTH = 2 * COEF_WIDTH + 3;
  localparam int SQ_PAIRS   = COEF_WIDTH + 1;
  localparam int SQ_STEPS   = SQ_PAIRS + FRAC_BITS + 1;
  localparam int RAD_WIDTH  = 2 * SQ_PAIRS;
  localparam int ROOT_WIDTH = SQ_STEPS;
  localparam int REM_WIDTH  = ROOT_WIDTH + 2;
  localparam int MAG_WIDTH  = COEF_WIDTH + FRAC_BITS + 3;
  localparam int NUM_WIDTH  = MAG_WIDTH + 1;
  localparam int DEN_WIDTH  = COEF_WIDTH + 2;
  localparam int QUO_WIDTH  = MAG_WIDTH + 1;
  localparam int DIV_LAT    = MAG_WIDTH + 2;
  localparam int LATENCY    = 2 + SQ_STEPS + 1 + DIV_LAT + 1;

  localparam logic signed [QUO_WIDTH-1:0] OUT_MAX =
    QUO_WIDTH'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [QUO_WIDTH-1:0] OUT_MIN =
    QUO_WIDTH'(-(64'sd1 <<< (OUT_WIDTH - 1)));

  typedef struct packed {
    logic                        has_roots;
    logic                        neg_a;
    logic [DEN_WIDTH-1:0]        den;
    logic signed [NUM_WIDTH-1:0] base;
  } side_t;

  typedef struct packed {
    logic has_roots;
    logic neg_a;
  } tag_t;

  function automatic logic signed [OUT_WIDTH-1:0] sat_out(
    input logic signed [QUO_WIDTH-1:0] v
  );
    logic signed [QUO_WIDTH-1:0] s;
    begin
      s = v;
      if (v > OUT_MAX) s = OUT_MAX;
      if (v < OUT_MIN) s = OUT_MIN;
      return s[OUT_WIDTH-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/quadratic_root_solver.sv =====
// quadratic_root_solver: top level; real roots of a*x^2+b*x+c in fixed point.
// Depends on qrs_pkg, qrs_front, qrs_sqrt and qrs_div.
//
//  channel  | handshake            | beat fields
//  ---------+----------------------+------------------------------------------
//  command  | start_i / busy_o     | coef_a_i, coef_b_i, coef_c_i
//  result   | done_o (one cycle)   | has_roots_o, root_low_o, root_high_o
//
// One beat is taken every cycle; busy_o is never raised.
// The pipeline runs through two front stages, one stage per
// square-root bit (34), a numerator stage, the divider (37) and the output register.
// Reset clears only the valid bits; the data registers are not reset.
// The receiver cannot stall, so the pipeline never stops.
module quadratic_root_solver (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_a_i,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_b_i,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_c_i,
  output logic                                   done_o,
  output logic                                   has_roots_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0]   root_low_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0]   root_high_o
);

  localparam int DL = qrs_pkg::DIV_LAT;

  assign busy_o = 1'b0;

  logic                           fr_valid, sq_valid;
  qrs_pkg::side_t                 fr_side, sq_side;
  logic [qrs_pkg::RAD_WIDTH-1:0]  fr_rad;
  logic [qrs_pkg::ROOT_WIDTH-1:0] sq_root;
  logic                           sq_exact;

  qrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .valid_o  (fr_valid),
    .side_o   (fr_side),
    .rad_o    (fr_rad)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .rad_i   (fr_rad),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (sq_root),
    .exact_o (sq_exact)
  );

  logic                                 num_valid_q;
  qrs_pkg::tag_t                        num_tag_q;
  logic signed [qrs_pkg::NUM_WIDTH-1:0] nlo_d, nhi_d, nlo_q, nhi_q;
  logic [qrs_pkg::DEN_WIDTH-1:0]        den_q;

  assign nlo_d = sq_side.base - qrs_pkg::NUM_WIDTH'(sq_root)
                 - qrs_pkg::NUM_WIDTH'(!sq_exact);
  assign nhi_d = sq_side.base + qrs_pkg::NUM_WIDTH'(sq_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_valid_q <= 1'b0;
    end else begin
      num_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    num_tag_q.has_roots <= sq_side.has_roots;
    num_tag_q.neg_a     <= sq_side.neg_a;
    nlo_q               <= nlo_d;
    nhi_q               <= nhi_d;
    den_q               <= sq_side.den;
  end

  logic signed [qrs_pkg::QUO_WIDTH-1:0] qlo, qhi;

  qrs_div u_div_lo (
    .clk_i (clk_i),
    .num_i (nlo_q),
    .den_i (den_q),
    .quo_o (qlo)
  );

  qrs_div u_div_hi (
    .clk_i (clk_i),
    .num_i (nhi_q),
    .den_i (den_q),
    .quo_o (qhi)
  );

  logic          vld_s [DL+1];
  qrs_pkg::tag_t tag_s [DL+1];

  assign vld_s[0] = num_valid_q;
  assign tag_s[0] = num_tag_q;

  for (genvar k = 0; k < DL; k++) begin : g_tag
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      tag_s[k+1] <= tag_s[k];
    end
  end

  logic signed [qrs_pkg::OUT_WIDTH-1:0] slo, shi, low_d, high_d, low_q, high_q;
  logic                                 done_q, has_q, neg_q;

  assign slo    = qrs_pkg::sat_out(qlo);
  assign shi    = qrs_pkg::sat_out(qhi);
  assign low_d  = !tag_s[DL].has_roots ? '0 : (tag_s[DL].neg_a ? shi : slo);
  assign high_d = !tag_s[DL].has_roots ? '0 : (tag_s[DL].neg_a ? slo : shi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_s[DL];
    end
  end

  always_ff @(posedge clk_i) begin
    has_q  <= tag_s[DL].has_roots;
    neg_q  <= tag_s[DL].neg_a;
    low_q  <= low_d;
    high_q <= high_d;
  end

  assign done_o      = done_q;
  assign has_roots_o = has_q;
  assign root_low_o  = low_q;
  assign root_high_o = high_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(qrs_pkg::LATENCY) done_o)
    else $error("result beat missing after pipeline latency");

  a_no_roots_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !has_roots_o |-> (root_low_o == '0) && (root_high_o == '0))
    else $error("roots not cleared when none exist");

  a_root_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && has_roots_o |->
      (neg_q ? (root_low_o >= root_high_o) : (root_low_o <= root_high_o)))
    else $error("root order wrong for sign of a");
`endif

endmodule

// ===== hw/rtl/qrs_front.sv =====
// qrs_front: products, discriminant and divider operands, two register stages.
// Depends on qrs_pkg.
module qrs_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_a_i,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_b_i,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_c_i,
  output logic                                   valid_o,
  output qrs_pkg::side_t                         side_o,
  output logic [qrs_pkg::RAD_WIDTH-1:0]          rad_o
);

  localparam int W = qrs_pkg::COEF_WIDTH;

  logic                    s1_valid_q;
  logic signed [2*W-1:0]   bb_d, bb_q, ac_d, ac_q;
  logic signed [W-1:0]     a_q, b_q;

  assign bb_d = coef_b_i * coef_b_i;
  assign ac_d = coef_a_i * coef_c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bb_q <= bb_d;
    ac_q <= ac_d;
    a_q  <= coef_a_i;
    b_q  <= coef_b_i;
  end

  logic signed [qrs_pkg::DISC_WIDTH-1:0] disc;
  logic                                  neg;
  logic [W-1:0]                          mag_a;
  logic signed [W:0]                     b_ext, b_sel;
  qrs_pkg::side_t                        side_d, side_q;
  logic                                  valid_q;
  logic [qrs_pkg::RAD_WIDTH-1:0]         rad_q;

  always_comb begin
    disc  = qrs_pkg::DISC_WIDTH'(bb_q) - (qrs_pkg::DISC_WIDTH'(ac_q) <<< 2);
    neg   = a_q[W-1];
    mag_a = neg ? (-a_q) : a_q;
    b_ext = (W+1)'(b_q);
    b_sel = neg ? (-b_ext) : b_ext;
    side_d.has_roots = !disc[qrs_pkg::DISC_WIDTH-1] && (a_q != '0);
    side_d.neg_a     = neg;
    side_d.den       = {mag_a, 2'b00};
    side_d.base      = -(qrs_pkg::NUM_WIDTH'(b_sel) <<< (qrs_pkg::FRAC_BITS + 1))
                       + qrs_pkg::NUM_WIDTH'({mag_a, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    rad_q  <= disc[qrs_pkg::RAD_WIDTH-1:0];
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rad_o   = rad_q;

endmodule

// ===== hw/rtl/qrs_sqrt.sv =====
// qrs_sqrt: pipelined bitwise square root, one result bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  qrs_pkg::side_t                  side_i,
  input  logic [qrs_pkg::RAD_WIDTH-1:0]   rad_i,
  output logic                            valid_o,
  output qrs_pkg::side_t                  side_o,
  output logic [qrs_pkg::ROOT_WIDTH-1:0]  root_o,
  output logic                            exact_o
);

  localparam int N  = qrs_pkg::SQ_STEPS;
  localparam int RW = qrs_pkg::REM_WIDTH;
  localparam int TW = qrs_pkg::ROOT_WIDTH;
  localparam int DW = qrs_pkg::RAD_WIDTH;

  logic                 vld_s  [N+1];
  qrs_pkg::side_t       side_s [N+1];
  logic [DW-1:0]        rad_s  [N+1];
  logic [RW-1:0]        rem_s  [N+1];
  logic [TW-1:0]        root_s [N+1];

  assign vld_s[0]  = valid_i;
  assign side_s[0] = side_i;
  assign rad_s[0]  = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [RW-1:0] ext, trial;
    logic          ge;

    assign ext   = {rem_s[i][RW-3:0], rad_s[i][DW-1 -: 2]};
    assign trial = {root_s[i], 2'b01};
    assign ge    = (ext >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[i+1] <= 1'b0;
      end else begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      side_s[i+1] <= side_s[i];
      rad_s[i+1]  <= {rad_s[i][DW-3:0], 2'b00};
      rem_s[i+1]  <= ge ? (ext - trial) : ext;
      root_s[i+1] <= {root_s[i][TW-2:0], ge};
    end
  end

  assign valid_o = vld_s[N];
  assign side_o  = side_s[N];
  assign root_o  = root_s[N];
  assign exact_o = (rem_s[N] == '0);

endmodule

// ===== hw/rtl/qrs_div.sv =====
// qrs_div: pipelined restoring floor division by a positive divisor.
// Depends on qrs_pkg.
module qrs_div (
  input  logic                                  clk_i,
  input  logic signed [qrs_pkg::NUM_WIDTH-1:0]  num_i,
  input  logic [qrs_pkg::DEN_WIDTH-1:0]         den_i,
  output logic signed [qrs_pkg::QUO_WIDTH-1:0]  quo_o
);

  localparam int M  = qrs_pkg::MAG_WIDTH;
  localparam int DN = qrs_pkg::DEN_WIDTH;

  logic          neg_q;
  logic [M-1:0]  mag_q;
  logic [DN-1:0] den_q;
  logic signed [qrs_pkg::NUM_WIDTH-1:0] abs_n;

  assign abs_n = num_i[qrs_pkg::NUM_WIDTH-1] ? (-num_i) : num_i;

  always_ff @(posedge clk_i) begin
    neg_q <= num_i[qrs_pkg::NUM_WIDTH-1];
    mag_q <= abs_n[M-1:0];
    den_q <= den_i;
  end

  logic          ng_s [M+1];
  logic [M-1:0]  nq_s [M+1];
  logic [DN-1:0] rm_s [M+1];
  logic [DN-1:0] dn_s [M+1];

  assign ng_s[0] = neg_q;
  assign nq_s[0] = mag_q;
  assign rm_s[0] = '0;
  assign dn_s[0] = den_q;

  for (genvar k = 0; k < M; k++) begin : g_bit
    logic [DN:0] sh, diff;
    logic        ge;

    assign sh   = {rm_s[k], nq_s[k][M-1]};
    assign diff = sh - {1'b0, dn_s[k]};
    assign ge   = (sh >= {1'b0, dn_s[k]});

    always_ff @(posedge clk_i) begin
      ng_s[k+1] <= ng_s[k];
      dn_s[k+1] <= dn_s[k];
      rm_s[k+1] <= ge ? diff[DN-1:0] : sh[DN-1:0];
      nq_s[k+1] <= {nq_s[k][M-2:0], ge};
    end
  end

  logic signed [qrs_pkg::QUO_WIDTH-1:0] quo_d, quo_q;

  assign quo_d = ng_s[M] ? ((~{1'b0, nq_s[M]}) + qrs_pkg::QUO_WIDTH'(rm_s[M] == '0))
                         : {1'b0, nq_s[M]};

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule
